FILE: sv/ffba_pkg.sv
// Shared types, constants and control bundles for the first-fit bump allocator.
package ffba_pkg;

    localparam int FREE_DEPTH     = 16;
    localparam int LIVE_DEPTH     = 32;
    localparam int MIN_ALIGN_LOG2 = 8;
    localparam int ADDR_BITS      = 32;

    localparam int FIDX_W     = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int LIDX_W     = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;
    localparam int FCNT_W     = $clog2(FREE_DEPTH + 1);
    localparam int SCAN_DEPTH = (FREE_DEPTH > LIVE_DEPTH) ? FREE_DEPTH : LIVE_DEPTH;
    localparam int SCAN_W     = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [ADDR_BITS:0]   addr_ext_t;
    typedef logic [FIDX_W-1:0]    fidx_t;
    typedef logic [LIDX_W-1:0]    lidx_t;
    typedef logic [2:0]           status_t;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_ZERO    = 3'd1;
    localparam status_t ST_OOM     = 3'd2;
    localparam status_t ST_UNKNOWN = 3'd3;
    localparam status_t ST_FULL    = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FSCAN,
        S_PICK,
        S_LSCAN,
        S_COMMIT,
        S_DONE
    } state_t;

    // Control bundle broadcast to every free-list cell.
    typedef struct packed {
        logic  rotate;
        logic  shift;
        logic  wr;
        fidx_t idx;
        addr_t wstart;
        addr_t wlen;
    } free_ctl_t;

    // Control bundle broadcast to every live-table cell.
    typedef struct packed {
        logic  rotate;
        logic  wr;
        logic  clr;
        lidx_t idx;
        addr_t wstart;
        addr_t wlen;
    } live_ctl_t;

endpackage

FILE: sv/ffba_free_cell.sv
// One free-list entry; rotates toward the head, compacts, or takes a write.
module ffba_free_cell (
    input  logic                clk,
    input  ffba_pkg::fidx_t     idx,
    input  ffba_pkg::free_ctl_t ctl,
    input  ffba_pkg::addr_t     nb_start,
    input  ffba_pkg::addr_t     nb_len,
    output ffba_pkg::addr_t     start,
    output ffba_pkg::addr_t     len
);
    import ffba_pkg::*;

    addr_t start_reg;
    addr_t len_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr && (ctl.idx == idx))
        begin
            start_reg <= ctl.wstart;
            len_reg   <= ctl.wlen;
        end
        else if (ctl.rotate || (ctl.shift && (idx >= ctl.idx)))
        begin
            start_reg <= nb_start;
            len_reg   <= nb_len;
        end
    end

    assign start = start_reg;
    assign len   = len_reg;

endmodule

FILE: sv/ffba_live_cell.sv
// One live-table entry with its valid bit; rotates, takes a write or clears.
module ffba_live_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ffba_pkg::lidx_t     idx,
    input  ffba_pkg::live_ctl_t ctl,
    input  ffba_pkg::addr_t     nb_start,
    input  ffba_pkg::addr_t     nb_len,
    input  logic                nb_valid,
    output ffba_pkg::addr_t     start,
    output ffba_pkg::addr_t     len,
    output logic                valid
);
    import ffba_pkg::*;

    addr_t start_reg;
    addr_t len_reg;
    logic  valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.wr && (ctl.idx == idx))
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.clr && (ctl.idx == idx))
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.rotate)
        begin
            valid_reg <= nb_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr && (ctl.idx == idx))
        begin
            start_reg <= ctl.wstart;
            len_reg   <= ctl.wlen;
        end
        else if (ctl.rotate)
        begin
            start_reg <= nb_start;
            len_reg   <= nb_len;
        end
    end

    assign start = start_reg;
    assign len   = len_reg;
    assign valid = valid_reg;

endmodule

FILE: sv/first_fit_bump_allocator.sv
// Top level of the first-fit offset allocator with bump-pointer fallback.
// Each request is processed on its own. An allocate request passes through
// S_PREP, a free-list scan, S_PICK, a live-table scan, S_COMMIT and S_DONE; a
// free request goes from S_PREP to the live-table scan, and a zero-size
// allocate from S_PREP to S_DONE. One that runs out of memory goes from S_PICK
// to S_DONE. The block returns to S_IDLE before the next request is taken. The
// free list and the live table are each a ring of cells that rotates once past
// a single comparator at its head, one entry per cycle, so a scan covers the
// whole ring. The first fitting free entry (only the first free_count entries
// count) is taken; otherwise the request is carved from the aligned bump
// pointer if it fits below the capacity register. The live table is searched
// for the lowest valid slot at the granted offset or, failing that, the lowest
// empty slot. A free moves the matching live entry to the tail of the free
// list, or drops it when the list is full. Sizes are rounded up to the request
// alignment, which is never below 2^MIN_ALIGN_LOG2. A finished result waits in
// an output register, so a new request is accepted while the previous result
// is still stalled; the next result then waits in its final state until the
// output register is free. Capacity is written through its own valid/ready
// port and must only be changed while the block is idle.
module first_fit_bump_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [31:0]               cfg_data,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      action,
    input  logic [31:0]               req_size,
    input  logic [4:0]                align_log2,
    input  logic [31:0]               free_offset,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [2:0]                status,
    output logic [31:0]               granted_offset,
    output logic [31:0]               granted_size,
    output logic [31:0]               high_water
);
    import ffba_pkg::*;

    localparam int W1 = ADDR_BITS + 1;
    localparam int W2 = ADDR_BITS + 2;
    localparam int CW = FCNT_W + SCAN_W;

    state_t state_reg, state_next;

    addr_t              capacity_reg;
    addr_t              bump_reg, bump_next;
    addr_t              peak_reg, peak_next;
    logic [FCNT_W-1:0]  fcount_reg, fcount_next;
    logic [SCAN_W-1:0]  cnt_reg, cnt_next;

    // Latched request.
    logic               act_reg;
    addr_t              size_reg;
    logic [4:0]         alog_reg;
    addr_t              foff_reg;

    // Working registers.
    addr_ext_t          amask_reg, amask_next;
    addr_ext_t          need_reg, need_next;
    logic               ffound_reg, ffound_next;
    fidx_t              fidx_reg, fidx_next;
    addr_t              rem_reg, rem_next;
    addr_t              key_reg, key_next;
    logic               mfound_reg, mfound_next;
    lidx_t              midx_reg, midx_next;
    addr_t              mlen_reg, mlen_next;
    logic               efound_reg, efound_next;
    lidx_t              eidx_reg, eidx_next;
    status_t            st_reg, st_next;
    addr_t              goff_reg, goff_next;
    addr_t              gsz_reg, gsz_next;

    logic               out_valid_reg;
    status_t            out_status_reg;
    addr_t              out_goff_reg;
    addr_t              out_gsz_reg;
    addr_t              out_hw_reg;

    free_ctl_t          fctl;
    live_ctl_t          lctl;

    addr_t              fs [FREE_DEPTH];
    addr_t              fl [FREE_DEPTH];
    addr_t              ls [LIVE_DEPTH];
    addr_t              ll [LIVE_DEPTH];
    logic               lv [LIVE_DEPTH];

    logic               req_acc;
    logic               out_free;
    logic [4:0]         lg;
    addr_ext_t          head_ao;
    addr_ext_t          head_pad;
    logic               head_fit;
    logic               head_live;
    addr_ext_t          bump_ao;
    logic [W2-1:0]      bump_end;
    logic               fscan_last;
    logic               lscan_last;

    // Cell rows: each cell takes its right neighbor on rotation.
    for (genvar i = 0; i < FREE_DEPTH; i++)
    begin : g_free
        ffba_free_cell u_cell (
            .clk      (clk),
            .idx      (FIDX_W'(i)),
            .ctl      (fctl),
            .nb_start (fs[(i + 1) % FREE_DEPTH]),
            .nb_len   (fl[(i + 1) % FREE_DEPTH]),
            .start    (fs[i]),
            .len      (fl[i])
        );
    end

    for (genvar i = 0; i < LIVE_DEPTH; i++)
    begin : g_live
        ffba_live_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (LIDX_W'(i)),
            .ctl      (lctl),
            .nb_start (ls[(i + 1) % LIVE_DEPTH]),
            .nb_len   (ll[(i + 1) % LIVE_DEPTH]),
            .nb_valid (lv[(i + 1) % LIVE_DEPTH]),
            .start    (ls[i]),
            .len      (ll[i]),
            .valid    (lv[i])
        );
    end

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign out_free  = !out_valid_reg || !rsp_stall;

    assign lg = (alog_reg < 5'(MIN_ALIGN_LOG2)) ? 5'(MIN_ALIGN_LOG2) : alog_reg;

    // Fit test of the free entry sitting at the head of the ring.
    assign head_ao  = ({1'b0, fs[0]} + amask_reg) & ~amask_reg;
    assign head_pad = head_ao - {1'b0, fs[0]};
    assign head_fit = (CW'(cnt_reg) < CW'(fcount_reg))
                      && ({2'b00, fl[0]} >= ({1'b0, head_pad} + {1'b0, need_reg}));
    assign head_live = lv[0] && (ls[0] == key_reg);

    assign bump_ao  = ({1'b0, bump_reg} + amask_reg) & ~amask_reg;
    assign bump_end = {1'b0, bump_ao} + {1'b0, need_reg};

    assign fscan_last = (cnt_reg == SCAN_W'(FREE_DEPTH - 1));
    assign lscan_last = (cnt_reg == SCAN_W'(LIVE_DEPTH - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (act_reg == ACT_FREE)
                begin
                    state_next = S_LSCAN;
                end
                else if (size_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                if (fscan_last)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (!ffound_reg && (bump_end > W2'(capacity_reg)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LSCAN;
                end
            end
            S_LSCAN:
            begin
                if (lscan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and cell control.
    always_comb
    begin
        bump_next   = bump_reg;
        peak_next   = peak_reg;
        fcount_next = fcount_reg;
        cnt_next    = cnt_reg;
        amask_next  = amask_reg;
        need_next   = need_reg;
        ffound_next = ffound_reg;
        fidx_next   = fidx_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        mfound_next = mfound_reg;
        midx_next   = midx_reg;
        mlen_next   = mlen_reg;
        efound_next = efound_reg;
        eidx_next   = eidx_reg;
        st_next     = st_reg;
        goff_next   = goff_reg;
        gsz_next    = gsz_reg;
        fctl        = '0;
        lctl        = '0;

        unique case (state_reg)
            S_PREP:
            begin
                amask_next  = (W1'(1) << lg) - W1'(1);
                need_next   = ({1'b0, size_reg} + ((W1'(1) << lg) - W1'(1)))
                              & ~((W1'(1) << lg) - W1'(1));
                cnt_next    = '0;
                ffound_next = 1'b0;
                mfound_next = 1'b0;
                efound_next = 1'b0;
                key_next    = foff_reg;
                st_next     = ST_ZERO;
                goff_next   = '0;
                gsz_next    = '0;
            end
            S_FSCAN:
            begin
                fctl.rotate = 1'b1;
                if (!ffound_reg && head_fit)
                begin
                    ffound_next = 1'b1;
                    fidx_next   = cnt_reg[FIDX_W-1:0];
                    key_next    = head_ao[ADDR_BITS-1:0];
                    rem_next    = ADDR_BITS'({1'b0, fl[0]} - head_pad - need_reg);
                end
                cnt_next = fscan_last ? '0 : cnt_reg + SCAN_W'(1);
            end
            S_PICK:
            begin
                if (!ffound_reg)
                begin
                    key_next = bump_ao[ADDR_BITS-1:0];
                    st_next  = ST_OOM;
                end
            end
            S_LSCAN:
            begin
                lctl.rotate = 1'b1;
                if (!mfound_reg && head_live)
                begin
                    mfound_next = 1'b1;
                    midx_next   = cnt_reg[LIDX_W-1:0];
                    mlen_next   = ll[0];
                end
                if (!efound_reg && !lv[0])
                begin
                    efound_next = 1'b1;
                    eidx_next   = cnt_reg[LIDX_W-1:0];
                end
                cnt_next = lscan_last ? '0 : cnt_reg + SCAN_W'(1);
            end
            S_COMMIT:
            begin
                if (act_reg == ACT_FREE)
                begin
                    if (!mfound_reg)
                    begin
                        st_next = ST_UNKNOWN;
                    end
                    else
                    begin
                        st_next  = ST_OK;
                        gsz_next = mlen_reg;
                        lctl.clr = 1'b1;
                        lctl.idx = midx_reg;
                        if (fcount_reg < FCNT_W'(FREE_DEPTH))
                        begin
                            fctl.wr     = 1'b1;
                            fctl.idx    = fcount_reg[FIDX_W-1:0];
                            fctl.wstart = key_reg;
                            fctl.wlen   = mlen_reg;
                            fcount_next = fcount_reg + FCNT_W'(1);
                        end
                    end
                end
                else if (!mfound_reg && !efound_reg)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    st_next     = ST_OK;
                    goff_next   = key_reg;
                    gsz_next    = need_reg[ADDR_BITS-1:0];
                    lctl.wr     = 1'b1;
                    lctl.idx    = mfound_reg ? midx_reg : eidx_reg;
                    lctl.wstart = key_reg;
                    lctl.wlen   = need_reg[ADDR_BITS-1:0];
                    if (ffound_reg)
                    begin
                        fctl.idx = fidx_reg;
                        if (rem_reg != '0)
                        begin
                            fctl.wr     = 1'b1;
                            fctl.wstart = key_reg + need_reg[ADDR_BITS-1:0];
                            fctl.wlen   = rem_reg;
                        end
                        else
                        begin
                            fctl.shift  = 1'b1;
                            fcount_next = fcount_reg - FCNT_W'(1);
                        end
                    end
                    else
                    begin
                        bump_next = key_reg + need_reg[ADDR_BITS-1:0];
                        if ((key_reg + need_reg[ADDR_BITS-1:0]) > peak_reg)
                        begin
                            peak_next = key_reg + need_reg[ADDR_BITS-1:0];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= '0;
            bump_reg      <= '0;
            peak_reg      <= '0;
            fcount_reg    <= '0;
            cnt_reg       <= '0;
            ffound_reg    <= 1'b0;
            mfound_reg    <= 1'b0;
            efound_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bump_reg   <= bump_next;
            peak_reg   <= peak_next;
            fcount_reg <= fcount_next;
            cnt_reg    <= cnt_next;
            ffound_reg <= ffound_next;
            mfound_reg <= mfound_next;
            efound_reg <= efound_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data[ADDR_BITS-1:0];
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            act_reg  <= action;
            size_reg <= req_size;
            alog_reg <= align_log2;
            foff_reg <= free_offset;
        end
        amask_reg <= amask_next;
        need_reg  <= need_next;
        fidx_reg  <= fidx_next;
        rem_reg   <= rem_next;
        key_reg   <= key_next;
        midx_reg  <= midx_next;
        mlen_reg  <= mlen_next;
        eidx_reg  <= eidx_next;
        st_reg    <= st_next;
        goff_reg  <= goff_next;
        gsz_reg   <= gsz_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= st_reg;
            out_goff_reg   <= goff_reg;
            out_gsz_reg    <= gsz_reg;
            out_hw_reg     <= peak_reg;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_offset = out_goff_reg;
    assign granted_size   = out_gsz_reg;
    assign high_water     = out_hw_reg;

    // The free list never holds more entries than it has cells.
    a_fcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= FCNT_W'(FREE_DEPTH))
        else $error("free list count beyond depth");

    // The peak mark only grows and always covers the bump pointer.
    a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (peak_reg >= $past(peak_reg)) && (bump_reg <= peak_reg))
        else $error("peak mark fell or bump pointer above it");

    // A granted offset is always aligned to the minimum alignment.
    a_grant_align: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_OK)
        |-> (granted_offset[0 +: (MIN_ALIGN_LOG2 > 0 ? MIN_ALIGN_LOG2 : 1)] == '0
             || MIN_ALIGN_LOG2 == 0))
        else $error("granted offset misaligned");

endmodule
